>>> src/sfcc_pkg.sv
// -----------------------------------------------------------------------------
// sfcc_pkg
// Shared types, constants and the CRC-8 byte step for the sensor frame checker.
// -----------------------------------------------------------------------------
package sfcc_pkg;

   localparam int unsigned FRAME_LEN = 9;
   localparam int unsigned POS_W     = 4;

   localparam logic [7:0]  CRC_INIT   = 8'hFF;
   localparam logic [7:0]  CRC_TOP    = 8'h80;
   localparam logic [7:0]  POLY_RESET = 8'h31;
   localparam logic [15:0] SHORT_FILL = 16'h7FFF;

   localparam logic [POS_W-1:0] POS_LAST = 4'(FRAME_LEN - 1);

   // register indexes of the configuration port
   localparam int unsigned CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_CHECK_ENABLE = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SENSOR_READY = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CRC_POLY     = 2'd2;

   // place of a byte inside its three-byte word group
   typedef enum logic [1:0] {
      SLOT_HIGH = 2'd0,
      SLOT_LOW  = 2'd1,
      SLOT_CRC  = 2'd2
   } slot_type;

   typedef struct packed {
      logic check_enable;
      logic sensor_ready;
      logic [7:0] crc_poly;
   } cfg_type;

   // first member lands in the top bits
   typedef struct packed {
      logic not_ready;
      logic flags_crc_bad;
      logic temp_crc_bad;
      logic flow_crc_bad;
      logic short_read;
      logic [15:0] status_word;
      logic signed [15:0] temperature_raw;
      logic signed [15:0] flow_raw;
   } result_type;

   localparam int unsigned RESULT_W = $bits(result_type);
   localparam int unsigned RSP_W    = ((RESULT_W + 7) / 8) * 8;

   // msb-first crc-8, no reflection, no final xor
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc,
                                            input logic [7:0] data,
                                            input logic [7:0] poly);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if ((c & CRC_TOP) != 8'h00) begin
            c = {c[6:0], 1'b0} ^ poly;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

>>> src/sfcc_frame.sv
// -----------------------------------------------------------------------------
// sfcc_frame
// Frame state of one sensor reply: byte position, running CRC, received words
// and failure bits; decides when a byte completes a result and builds it.
// -----------------------------------------------------------------------------
module sfcc_frame
   import sfcc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       step_en,
   input  logic [7:0] data_byte,
   input  logic       transfer_end,
   output logic       result_valid,
   output result_type result
);

   logic [POS_W-1:0] byte_pos_ff, byte_pos_in;
   logic [7:0]       crc_ff, crc_in;
   logic [7:0]       high_ff, high_in;
   logic [15:0]      words_ff [3];
   logic [15:0]      words_in [3];
   logic [2:0]       fail_ff, fail_in;

   slot_type   slot;
   logic [1:0] word_idx;
   logic [7:0] crc_step;
   logic       full_frame;

   // position to word index and slot
   always_comb begin
      unique case (byte_pos_ff)
         4'd0:    begin word_idx = 2'd0; slot = SLOT_HIGH; end
         4'd1:    begin word_idx = 2'd0; slot = SLOT_LOW;  end
         4'd2:    begin word_idx = 2'd0; slot = SLOT_CRC;  end
         4'd3:    begin word_idx = 2'd1; slot = SLOT_HIGH; end
         4'd4:    begin word_idx = 2'd1; slot = SLOT_LOW;  end
         4'd5:    begin word_idx = 2'd1; slot = SLOT_CRC;  end
         4'd6:    begin word_idx = 2'd2; slot = SLOT_HIGH; end
         4'd7:    begin word_idx = 2'd2; slot = SLOT_LOW;  end
         4'd8:    begin word_idx = 2'd2; slot = SLOT_CRC;  end
         default: begin word_idx = 2'd0; slot = SLOT_HIGH; end
      endcase
   end

   always_comb begin
      crc_step = crc8_byte((slot == SLOT_HIGH) ? CRC_INIT : crc_ff, data_byte,
                           cfg.crc_poly);
      crc_in   = crc_ff;
      high_in  = high_ff;
      fail_in  = fail_ff;
      for (int i = 0; i < 3; i++) begin
         words_in[i] = words_ff[i];
      end
      unique case (slot)
         SLOT_HIGH: begin
            crc_in  = crc_step;
            high_in = data_byte;
         end
         SLOT_LOW: begin
            crc_in = crc_step;
            words_in[word_idx] = {high_ff, data_byte};
         end
         SLOT_CRC: begin
            if (data_byte != crc_ff) begin
               fail_in = fail_ff | (3'b001 << word_idx);
            end
         end
         default: begin
            crc_in = crc_ff;
         end
      endcase

      full_frame   = (byte_pos_ff == POS_LAST);
      result_valid = full_frame || transfer_end;
      byte_pos_in  = byte_pos_ff + 4'd1;

      if (!cfg.sensor_ready) begin
         result.flow_raw        = SHORT_FILL;
         result.temperature_raw = SHORT_FILL;
         result.status_word     = SHORT_FILL;
         result.short_read      = 1'b1;
         result.flow_crc_bad    = 1'b1;
         result.temp_crc_bad    = 1'b1;
         result.flags_crc_bad   = 1'b1;
         result.not_ready       = 1'b1;
      end else if (!full_frame) begin
         result.flow_raw        = SHORT_FILL;
         result.temperature_raw = SHORT_FILL;
         result.status_word     = SHORT_FILL;
         result.short_read      = 1'b1;
         result.flow_crc_bad    = 1'b0;
         result.temp_crc_bad    = 1'b0;
         result.flags_crc_bad   = 1'b0;
         result.not_ready       = 1'b0;
      end else begin
         result.flow_raw        = words_in[0];
         result.temperature_raw = words_in[1];
         result.status_word     = words_in[2];
         result.short_read      = 1'b0;
         result.flow_crc_bad    = fail_in[0] & cfg.check_enable;
         result.temp_crc_bad    = fail_in[1] & cfg.check_enable;
         result.flags_crc_bad   = fail_in[2] & cfg.check_enable;
         result.not_ready       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff <= '0;
         crc_ff      <= CRC_INIT;
         fail_ff     <= '0;
      end else if (step_en) begin
         if (result_valid) begin
            byte_pos_ff <= '0;
            crc_ff      <= CRC_INIT;
            fail_ff     <= '0;
         end else begin
            byte_pos_ff <= byte_pos_in;
            crc_ff      <= crc_in;
            fail_ff     <= fail_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         high_ff <= high_in;
         for (int i = 0; i < 3; i++) begin
            words_ff[i] <= words_in[i];
         end
      end
   end

   a_pos_in_frame: assert property (@(posedge clock) disable iff (reset)
      byte_pos_ff <= POS_LAST)
      else $error("byte position beyond frame");

   a_restart_after_result: assert property (@(posedge clock) disable iff (reset)
      step_en && result_valid |=> byte_pos_ff == '0 && fail_ff == '0)
      else $error("frame state not cleared after result");

   a_not_ready_flags: assert property (@(posedge clock) disable iff (reset)
      result_valid && !cfg.sensor_ready |->
         result.not_ready && result.short_read && result.flow_crc_bad
         && result.temp_crc_bad && result.flags_crc_bad)
      else $error("not-ready result missing flags");

endmodule

>>> src/sensor_frame_crc_checker_top.sv
// -----------------------------------------------------------------------------
// sensor_frame_crc_checker_top
// Receives the bytes of a nine-byte sensor reply and reports its three words
// with per-word CRC-8 check flags.
// -----------------------------------------------------------------------------
// Bytes come in on the req_ stream, one per transfer, with req_tlast marking
// the last byte the bus delivered. One rsp_ transfer leaves per frame: after
// the ninth byte, or after an earlier byte with req_tlast set (short read).
// The user writes registers check_enable, sensor_ready and crc_poly through
// the csr_ port only while no frame is in flight; the block does not check it.
// Each accepted byte sits in the input register, where the CRC-8 step (eight
// unrolled shift/xor stages) and the frame state update run; when the byte
// moves on and completes a frame, the result register is loaded. A result is
// therefore valid once its final byte has moved from the input register into
// the result register. One byte per cycle is taken unless a stall holds it.
// When the receiver stalls, the result waits in the result register and
// bytes keep flowing until a second result is ready to leave; then the input
// register holds it and req_tready drops until the first is taken.
// Reset clears the frame, empties both registers and restores the register
// defaults (checks on, sensor not ready, polynomial 0x31).
// -----------------------------------------------------------------------------
module sensor_frame_crc_checker_top
   import sfcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // data_byte[7:0]
   input  logic                  req_tlast,   // transfer_end
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // flow_raw, temperature_raw, status_word, short_read, flow_crc_bad,
   // temp_crc_bad, flags_crc_bad, not_ready, zero pad
   output logic [RSP_W-1:0]      rsp_tdata,
   input  logic                  csr_wen,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [7:0]            csr_wdata
);

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;
   logic       out_valid_ff;
   result_type out_ff;

   logic       step_en;
   logic       result_valid;
   result_type result;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.check_enable <= 1'b1;
         cfg_ff.sensor_ready <= 1'b0;
         cfg_ff.crc_poly     <= POLY_RESET;
      end else if (csr_wen) begin
         unique case (csr_addr)
            CSR_CHECK_ENABLE: cfg_ff.check_enable <= csr_wdata[0];
            CSR_SENSOR_READY: cfg_ff.sensor_ready <= csr_wdata[0];
            CSR_CRC_POLY:     cfg_ff.crc_poly     <= csr_wdata;
            default:          cfg_ff              <= cfg_ff;
         endcase
      end
   end

   // a held byte moves on unless its result would hit a full result register
   assign step_en    = in_valid_ff && (!result_valid || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
   end

   sfcc_frame u_frame (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .step_en      (step_en),
      .data_byte    (in_byte_ff),
      .transfer_end (in_end_ff),
      .result_valid (result_valid),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step_en && result_valid) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en && result_valid) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_W - RESULT_W)'(0), out_ff};

   a_held_byte_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step_en |=> in_valid_ff && $stable(in_byte_ff)
         && $stable(in_end_ff))
      else $error("held byte lost or overwritten");

   a_no_result_overrun: assert property (@(posedge clock) disable iff (reset)
      step_en && result_valid |-> !out_valid_ff || rsp_tready)
      else $error("result register overwritten");

   a_result_loads: assert property (@(posedge clock) disable iff (reset)
      step_en && result_valid |=> out_valid_ff)
      else $error("result not presented");

endmodule

>>> tb/sensor_frame_crc_checker_top_tb.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// sensor_frame_crc_checker_top_tb
// Drives byte streams of sensor replies into the frame checker and compares
// every reported frame against a behavioural copy of the receiver.
// -----------------------------------------------------------------------------
// A short directed run covers the not-ready state, short reads, extreme
// words, failed checks and a polynomial change in the middle of a frame.
// Random phases then send well-formed replies with random words and
// occasionally corrupted check bytes, mixed with short replies and noise,
// under several register settings. One phase holds the result side off for a
// long stretch so that the block backs up and stalls its input.
// -----------------------------------------------------------------------------
module sensor_frame_crc_checker_top_tb
   import sfcc_pkg::*;
();

   class frame_result_board;
      logic check_en;
      logic ready;
      logic [7:0] poly;
      int unsigned pos;
      logic [7:0] crc;
      logic [7:0] hold;
      logic [15:0] words [3];
      logic [2:0] fails;
      result_type pending_frames [$];
      int unsigned bad_frames;

      function new();
         check_en   = 1'b1;
         ready      = 1'b0;
         poly       = POLY_RESET;
         bad_frames = 0;
         clear_frame();
      endfunction

      static function logic [7:0] crc_step(logic [7:0] crc_in, logic [7:0] data,
                                           logic [7:0] g);
         logic [7:0] c;
         logic msb;
         c = crc_in ^ data;
         repeat (8) begin
            msb = c[7];
            c = c << 1;
            if (msb) c = c ^ g;
         end
         return c;
      endfunction

      function void clear_frame();
         pos      = 0;
         crc      = CRC_INIT;
         hold     = 8'h00;
         words[0] = 16'h0000;
         words[1] = 16'h0000;
         words[2] = 16'h0000;
         fails    = 3'b000;
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] a, logic [7:0] v);
         case (a)
            CSR_CHECK_ENABLE: check_en = v[0];
            CSR_SENSOR_READY: ready = v[0];
            CSR_CRC_POLY: poly = v;
            default: ;
         endcase
      endfunction

      function void absorb_byte(logic [7:0] b, logic last);
         int unsigned w;
         slot_type slot;
         result_type r;
         if (pos >= FRAME_LEN) pos = 0;
         w    = pos / 3;
         slot = slot_type'(2'(pos % 3));
         case (slot)
            SLOT_HIGH: begin
               crc  = crc_step(CRC_INIT, b, poly);
               hold = b;
            end
            SLOT_LOW: begin
               crc      = crc_step(crc, b, poly);
               words[w] = {hold, b};
            end
            default: begin
               if (b != crc) fails[w] = 1'b1;
            end
         endcase
         pos++;
         if (pos < FRAME_LEN && !last) return;
         r = '0;
         if (!ready) begin
            r.flow_raw        = SHORT_FILL;
            r.temperature_raw = SHORT_FILL;
            r.status_word     = SHORT_FILL;
            r.short_read      = 1'b1;
            r.flow_crc_bad    = 1'b1;
            r.temp_crc_bad    = 1'b1;
            r.flags_crc_bad   = 1'b1;
            r.not_ready       = 1'b1;
         end else if (pos < FRAME_LEN) begin
            r.flow_raw        = SHORT_FILL;
            r.temperature_raw = SHORT_FILL;
            r.status_word     = SHORT_FILL;
            r.short_read      = 1'b1;
         end else begin
            r.flow_raw        = words[0];
            r.temperature_raw = words[1];
            r.status_word     = words[2];
            if (check_en) begin
               r.flow_crc_bad  = fails[0];
               r.temp_crc_bad  = fails[1];
               r.flags_crc_bad = fails[2];
            end
         end
         pending_frames.push_back(r);
         clear_frame();
      endfunction

      function void check_frame_result(result_type got);
         result_type want;
         if (pending_frames.size() == 0) begin
            bad_frames++;
            if (bad_frames <= 10) $display("unexpected result transfer: %h", got);
            return;
         end
         want = pending_frames.pop_front();
         if (got.flow_raw !== want.flow_raw || got.temperature_raw !== want.temperature_raw ||
             got.status_word !== want.status_word || got.short_read !== want.short_read ||
             got.flow_crc_bad !== want.flow_crc_bad ||
             got.temp_crc_bad !== want.temp_crc_bad ||
             got.flags_crc_bad !== want.flags_crc_bad || got.not_ready !== want.not_ready)
         begin
            bad_frames++;
            if (bad_frames <= 10) begin
               $display("frame mismatch at %0t: expected flow %h temp %h status %h",
                        $realtime, want.flow_raw, want.temperature_raw, want.status_word);
               $display("   expected flags %b%b%b%b%b",
                        want.short_read, want.flow_crc_bad, want.temp_crc_bad,
                        want.flags_crc_bad, want.not_ready);
               $display("   actual   flow %h temp %h status %h flags %b%b%b%b%b",
                        got.flow_raw, got.temperature_raw, got.status_word,
                        got.short_read, got.flow_crc_bad, got.temp_crc_bad,
                        got.flags_crc_bad, got.not_ready);
            end
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;   // data_byte[7:0]
   logic                  req_tlast;   // transfer_end
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // flow_raw, temperature_raw, status_word, short_read, flow_crc_bad,
   // temp_crc_bad, flags_crc_bad, not_ready, zero pad
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_wen;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [7:0]            csr_wdata;

   frame_result_board sb;
   bit gaps_on;
   bit hold_req;
   logic [7:0] cur_poly;

   sensor_frame_crc_checker_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("Mismatches found");
      $finish;
   end

   // result side: random stalls, plus a long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            for (int n = 0; n < 60; n++) begin
               rsp_tready <= 1'b0;
               @(negedge clock);
            end
            hold_req = 1'b0;
         end
         rsp_tready <= !(gaps_on && $urandom_range(99) < 8);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wen) sb.write_reg(csr_addr, csr_wdata);
         if (rsp_tvalid && rsp_tready) begin
            sb.check_frame_result(result_type'(rsp_tdata[RESULT_W-1:0]));
         end
         if (req_tvalid && req_tready) sb.absorb_byte(req_tdata, req_tlast);
      end
   end

   task automatic send_byte(input logic [7:0] d, input logic last);
      while (gaps_on && $urandom_range(99) < 8) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // sends bytes first..nbytes-1 of a reply built from three words
   task automatic send_frame(input logic [15:0] w0, input logic [15:0] w1,
                             input logic [15:0] w2, input logic [2:0] corrupt,
                             input int unsigned first, input int unsigned nbytes,
                             input logic end_mark);
      logic [7:0] bytes [9];
      logic [15:0] wv [3];
      logic [7:0] c;
      wv[0] = w0;
      wv[1] = w1;
      wv[2] = w2;
      for (int i = 0; i < 3; i++) begin
         c = frame_result_board::crc_step(CRC_INIT, wv[i][15:8], cur_poly);
         c = frame_result_board::crc_step(c, wv[i][7:0], cur_poly);
         if (corrupt[i]) c = c ^ 8'($urandom_range(255, 1));
         bytes[3*i]   = wv[i][15:8];
         bytes[3*i+1] = wv[i][7:0];
         bytes[3*i+2] = c;
      end
      for (int i = first; i < nbytes; i++) begin
         send_byte(bytes[i], (i == nbytes - 1) ? end_mark : 1'b0);
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending_frames.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] a, input logic [7:0] v);
      csr_wen   <= 1'b1;
      csr_addr  <= a;
      csr_wdata <= v;
      @(negedge clock);
      csr_wen <= 1'b0;
      @(negedge clock);
      if (a == CSR_CRC_POLY) cur_poly = v;
   endtask

   function automatic logic [15:0] pick_word();
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h8000;
         3: return 16'h7FFF;
         default: return 16'($urandom_range(65535));
      endcase
   endfunction

   task automatic run_phase(input logic ce, input logic rdy, input logic [7:0] g,
                            input int unsigned n_items);
      int unsigned sent;
      int unsigned pick;
      int unsigned nb;
      logic [2:0] bad;
      write_csr(CSR_CHECK_ENABLE, {7'd0, ce});
      write_csr(CSR_SENSOR_READY, {7'd0, rdy});
      write_csr(CSR_CRC_POLY, g);
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         bad  = {$urandom_range(99) < 15, $urandom_range(99) < 15, $urandom_range(99) < 15};
         if (pick < 70) begin
            send_frame(pick_word(), pick_word(), pick_word(), bad, 0, 9, $urandom_range(1));
            sent += 9;
         end else if (pick < 85) begin
            nb = $urandom_range(8, 1);
            send_frame(pick_word(), pick_word(), pick_word(), bad, 0, nb, 1'b1);
            sent += nb;
         end else begin
            // noise, closed by an end mark so the next reply starts aligned
            nb = $urandom_range(12, 1);
            for (int i = 0; i < nb; i++) begin
               send_byte(8'($urandom_range(255)), (i == nb - 1) || ($urandom_range(99) < 10));
            end
            sent += nb;
         end
      end
      settle();
   endtask

   initial begin
      sb         = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tlast  = 1'b0;
      csr_wen    = 1'b0;
      csr_addr   = CSR_CHECK_ENABLE;
      csr_wdata  = 8'h00;
      gaps_on    = 1'b1;
      hold_req   = 1'b0;
      cur_poly   = POLY_RESET;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // sensor not ready after reset: full and short replies
      send_frame(16'h0000, 16'hFFFF, 16'h8000, 3'b000, 0, 9, 1'b1);
      send_frame(16'h1234, 16'h5678, 16'h9ABC, 3'b000, 0, 2, 1'b1);
      settle();
      write_csr(CSR_SENSOR_READY, 8'h01);
      // clean reply, end mark on the ninth byte
      send_frame(16'h0000, 16'hFFFF, 16'h7FFF, 3'b000, 0, 9, 1'b1);
      // short read on the first byte
      send_frame(16'h8000, 16'h0000, 16'h0000, 3'b000, 0, 1, 1'b1);
      // all three checks fail, polynomial changed inside the second word
      send_frame(16'hFFFF, 16'h0000, 16'h8000, 3'b111, 0, 4, 1'b0);
      settle();
      write_csr(CSR_CRC_POLY, 8'h07);
      send_frame(16'hFFFF, 16'h0000, 16'h8000, 3'b111, 4, 9, 1'b0);
      settle();

      run_phase(1'b1, 1'b1, POLY_RESET, 100);
      run_phase(1'b0, 1'b1, 8'($urandom_range(255)), 100);
      run_phase(1'b1, 1'b1, 8'h00, 100);
      // long stretch without idling while the result side is held off
      gaps_on  = 1'b0;
      hold_req = 1'b1;
      run_phase(1'b1, 1'b1, 8'hFF, 100);
      gaps_on = 1'b1;
      run_phase(1'b1, 1'b0, 8'hA5, 100);
      run_phase(1'b0, 1'b1, 8'hFF, 100);
      run_phase(1'b1, 1'b1, 8'($urandom_range(255)), 100);

      repeat (10) @(negedge clock);
      if (sb.bad_frames == 0 && sb.pending_frames.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
